// File: rtl/stce_pkg.sv
// shared widths, register indexes and types for the terrain cell elevation core
// no dependencies; every other file imports this package
package stce_pkg;

  // fixed point layout
  localparam int FRAC_BITS    = 12;
  localparam int COORD_W      = 12;
  localparam int REG_W        = 32;
  localparam int CELL_W       = 24;
  localparam int POS_W        = 38;
  localparam int GRAD_W       = 55;
  localparam int SUM_W        = 58;
  localparam int ELEV_W       = 40;
  localparam int PIPE_DEPTH   = 9;

  // sine table geometry
  localparam int SINE_IDX_W   = 10;
  localparam int SINE_ENTRIES = 1 << SINE_IDX_W;
  localparam int SINE_ADDR_W  = SINE_IDX_W + 1;
  localparam int SINE_MAG_W   = 31;
  localparam int SINE_W       = 32;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_ELEV  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRAD_EAST  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRAD_NORTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WAVE_RATE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_EAST_START = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_NORTH_START = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE  = 3'd7;

  localparam logic [CELL_W-1:0] CELL_SIZE_RESET = 24'd4096;

  // one sine lookup: table address and sign of the result
  typedef struct packed {
    logic                   neg;
    logic [SINE_ADDR_W-1:0] addr;
  } sine_req_t;

endpackage

// File: rtl/stce_grad.sv
// gradient term round(g * pos / 2^16) over two stages: partial products, then the rounded sum
// depends on stce_pkg
module stce_grad (
  input  logic                               clk_i,
  input  logic signed [stce_pkg::REG_W-1:0]  grad_i,
  input  logic signed [stce_pkg::POS_W-1:0]  pos_i,
  output logic signed [stce_pkg::GRAD_W-1:0] term_o
);
  import stce_pkg::*;

  localparam int LO_W  = 16;
  localparam int HI_W  = POS_W - LO_W;
  localparam int HP_W  = REG_W + HI_W;
  localparam int LP_W  = REG_W + LO_W + 1;
  localparam int LR_W  = LP_W + 1;
  localparam int LS_W  = LR_W - LO_W;

  logic signed [HP_W-1:0]   hi_prod_d, hi_prod_q;
  logic signed [LP_W-1:0]   lo_prod_d, lo_prod_q;
  logic signed [LR_W-1:0]   lo_rnd;
  logic signed [GRAD_W-1:0] term_d, term_q;

  // split pos into signed upper part and unsigned low 16 bits
  assign hi_prod_d = HP_W'(grad_i) * HP_W'($signed(pos_i[POS_W-1:LO_W]));
  assign lo_prod_d = LP_W'(grad_i) * LP_W'($signed({1'b0, pos_i[LO_W-1:0]}));

  // recombine with the rounding half on the low product
  assign lo_rnd = {lo_prod_q[LP_W-1], lo_prod_q} + (LR_W'(1) <<< (LO_W - 1));
  assign term_d = {{(GRAD_W-HP_W){hi_prod_q[HP_W-1]}}, hi_prod_q}
                + {{(GRAD_W-LS_W){lo_rnd[LR_W-1]}}, lo_rnd[LR_W-1:LO_W]};

  always_ff @(posedge clk_i) begin
    hi_prod_q <= hi_prod_d;
    lo_prod_q <= lo_prod_d;
    term_q    <= term_d;
  end

  assign term_o = term_q;

endmodule

// File: rtl/stce_phase.sv
// phase of one axis: pos * wave rate in turns, turned into a sine table lookup
// depends on stce_pkg
module stce_phase (
  input  logic                              clk_i,
  input  logic signed [stce_pkg::POS_W-1:0] pos_i,
  input  logic        [stce_pkg::REG_W-1:0] rate_i,
  output stce_pkg::sine_req_t               req_o
);
  import stce_pkg::*;

  localparam int PH_W   = FRAC_BITS + 32;
  localparam int LO_W   = 16;
  localparam int HI_W   = PH_W - LO_W;
  localparam int PL_W   = LO_W + REG_W;

  logic [PH_W-1:0]       pos_ext;
  logic [PL_W-1:0]       pl_d, pl_q;
  logic [HI_W-1:0]       ph_hi_d, ph_hi_q;
  logic [PH_W-1:0]       full;
  logic [31:0]           phase;
  logic [SINE_IDX_W-1:0] idx;
  sine_req_t             req_d, req_q;

  // only the low PH_W bits of the product reach the phase
  assign pos_ext = {{(PH_W-POS_W){pos_i[POS_W-1]}}, pos_i};
  assign pl_d    = PL_W'(pos_ext[LO_W-1:0]) * PL_W'(rate_i);
  assign ph_hi_d = pos_ext[PH_W-1:LO_W] * rate_i[HI_W-1:0];

  // wrapped phase, quadrant and table index
  assign full  = {ph_hi_q, {LO_W{1'b0}}} + pl_q[PH_W-1:0];
  assign phase = full[PH_W-1:FRAC_BITS];
  assign idx   = phase[29 -: SINE_IDX_W];

  // odd quadrants mirror the table, the upper half negates
  always_comb begin
    req_d.neg = phase[31];
    if (phase[30]) begin
      req_d.addr = SINE_ADDR_W'(SINE_ENTRIES) - {1'b0, idx};
    end else begin
      req_d.addr = {1'b0, idx};
    end
  end

  always_ff @(posedge clk_i) begin
    pl_q    <= pl_d;
    ph_hi_q <= ph_hi_d;
    req_q   <= req_d;
  end

  assign req_o = req_q;

endmodule

// File: rtl/stce_sine_rom.sv
// quarter-wave sine rom with two registered read ports and signed output
// depends on stce_pkg; contents built at elaboration from an integer series
module stce_sine_rom (
  input  logic                               clk_i,
  input  stce_pkg::sine_req_t                req_a_i,
  input  stce_pkg::sine_req_t                req_b_i,
  output logic signed [stce_pkg::SINE_W-1:0] sine_a_o,
  output logic signed [stce_pkg::SINE_W-1:0] sine_b_o
);
  import stce_pkg::*;

  typedef logic [SINE_MAG_W-1:0] rom_t [0:SINE_ENTRIES];

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint          ONE_Q30     = 64'sd1073741824;
  localparam longint unsigned TAYLOR_DIV [1:7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                   64'd110, 64'd156, 64'd210};

  // truncated 8 term series, clamped to [0, 1.0] in q1.30
  function automatic rom_t build_rom();
    rom_t            tab;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint          sum;
    for (int i = 0; i <= SINE_ENTRIES; i++) begin
      x   = (64'(i) * HALF_PI_Q30 + 64'(SINE_ENTRIES / 2)) / 64'(SINE_ENTRIES);
      x2  = (x * x) >> 30;
      t   = x;
      sum = longint'(x);
      for (int k = 1; k <= 7; k++) begin
        t = ((t * x2) >> 30) / TAYLOR_DIV[k];
        if (k[0]) begin
          sum = sum - longint'(t);
        end else begin
          sum = sum + longint'(t);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      if (sum > ONE_Q30) begin
        sum = ONE_Q30;
      end
      tab[i] = SINE_MAG_W'(sum);
    end
    return tab;
  endfunction

  localparam rom_t ROM_DATA = build_rom();

  logic signed [SINE_W-1:0] mag_a, mag_b;
  logic signed [SINE_W-1:0] sine_a_q, sine_b_q;

  assign mag_a = $signed({1'b0, ROM_DATA[req_a_i.addr]});
  assign mag_b = $signed({1'b0, ROM_DATA[req_b_i.addr]});

  // registered reads with sign applied
  always_ff @(posedge clk_i) begin
    sine_a_q <= req_a_i.neg ? -mag_a : mag_a;
    sine_b_q <= req_b_i.neg ? -mag_b : mag_b;
  end

  assign sine_a_o = sine_a_q;
  assign sine_b_o = sine_b_q;

endmodule

// File: rtl/synthetic_terrain_cell_elevation_core.sv
// Synthetic terrain cell elevation core.
// An item (cell_col_i, cell_row_i) is taken at a rising edge with start high
// and busy low. busy never rises: the datapath is a 9 stage pipeline with each
// multiplier in a stage of its own, so one item enters every clock cycle.
// The result (elevation_o, saturated_o) is on the ports for exactly one cycle,
// marked by result_strobe_o, once the item has passed through every stage
// of the pipeline; results leave in order.
// The receiver cannot stall; results simply leave one per cycle.
// Configuration writes use cfg_valid_i/cfg_ready_o with cfg_index_i and
// cfg_data_i; cfg_ready_o is always high. Write registers only while the
// pipeline is empty. Reset clears the pipeline valid bits and sets every
// register to zero except cell size, which resets to 1.0 m.
// Stages: input reg, position, partial products, gradient terms and table
// address, sine read with plane sum, sine product, product rounding,
// amplitude product, final sum with saturation.
// depends on stce_pkg, stce_grad, stce_phase, stce_sine_rom
module synthetic_terrain_cell_elevation_core (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start,
  output logic                                   busy,
  input  logic        [stce_pkg::COORD_W-1:0]    cell_col_i,
  input  logic        [stce_pkg::COORD_W-1:0]    cell_row_i,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic        [stce_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic        [stce_pkg::REG_W-1:0]      cfg_data_i,
  output logic                                   result_strobe_o,
  output logic signed [stce_pkg::ELEV_W-1:0]     elevation_o,
  output logic                                   saturated_o
);
  import stce_pkg::*;

  localparam int CP_W = COORD_W + CELL_W;
  localparam int PR_W = 2 * SINE_W;
  localparam int UN_W = PR_W - 30;

  localparam logic signed [SUM_W-1:0] ELEV_MAX =
    {{(SUM_W-ELEV_W+1){1'b0}}, {(ELEV_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] ELEV_MIN =
    {{(SUM_W-ELEV_W+1){1'b1}}, {(ELEV_W-1){1'b0}}};
  localparam logic signed [PR_W-1:0] ROUND_Q30 = PR_W'(1) <<< 29;

  // configuration registers
  logic signed [REG_W-1:0] base_q, grad_e_q, grad_n_q, amp_q, east_q, north_q;
  logic        [REG_W-1:0] rate_q;
  logic        [CELL_W-1:0] cell_q;

  // pipeline valid bits
  logic [PIPE_DEPTH-1:0] valid_d, valid_q;
  logic                  accept;

  // datapath
  logic [COORD_W-1:0]       col_q, row_q;
  logic [CP_W-1:0]          col_prod, row_prod;
  logic signed [POS_W-1:0]  e_d, e_q, n_d, n_q;
  logic signed [GRAD_W-1:0] term_e, term_n;
  sine_req_t                req_e, req_n;
  logic signed [SINE_W-1:0] sine_e, sine_n;
  logic signed [SUM_W-1:0]  plane_d, plane5_q, plane6_q, plane7_q, plane8_q;
  logic signed [PR_W-1:0]   sprod_d, sprod_q, sprod_rnd;
  logic signed [SINE_W-1:0] p_d, p_q;
  logic signed [PR_W-1:0]   up_d, up_q, up_rnd;
  logic signed [UN_W-1:0]   und;
  logic signed [SUM_W-1:0]  total;
  logic signed [ELEV_W-1:0] elev_d, elev_q;
  logic                     sat_d, sat_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start & ~busy;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= '0;
      grad_e_q <= '0;
      grad_n_q <= '0;
      amp_q    <= '0;
      rate_q   <= '0;
      east_q   <= '0;
      north_q  <= '0;
      cell_q   <= CELL_SIZE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_BASE_ELEV:   base_q   <= cfg_data_i;
        REG_GRAD_EAST:   grad_e_q <= cfg_data_i;
        REG_GRAD_NORTH:  grad_n_q <= cfg_data_i;
        REG_AMPLITUDE:   amp_q    <= cfg_data_i;
        REG_WAVE_RATE:   rate_q   <= cfg_data_i;
        REG_EAST_START:  east_q   <= cfg_data_i;
        REG_NORTH_START: north_q  <= cfg_data_i;
        REG_CELL_SIZE:   cell_q   <= cfg_data_i[CELL_W-1:0];
        default: ;
      endcase
    end
  end

  // valid bits shift along with the data
  assign valid_d = {valid_q[PIPE_DEPTH-2:0], accept};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // cell position relative to the reference
  assign col_prod = CP_W'(col_q) * CP_W'(cell_q);
  assign row_prod = CP_W'(row_q) * CP_W'(cell_q);
  assign e_d = {{(POS_W-REG_W){east_q[REG_W-1]}}, east_q}
             + {{(POS_W-CP_W){1'b0}}, col_prod};
  assign n_d = {{(POS_W-REG_W){north_q[REG_W-1]}}, north_q}
             - {{(POS_W-CP_W){1'b0}}, row_prod};

  always_ff @(posedge clk_i) begin
    col_q <= cell_col_i;
    row_q <= cell_row_i;
    e_q   <= e_d;
    n_q   <= n_d;
  end

  // gradient terms
  stce_grad u_grad_e (
    .clk_i  (clk_i),
    .grad_i (grad_e_q),
    .pos_i  (e_q),
    .term_o (term_e)
  );

  stce_grad u_grad_n (
    .clk_i  (clk_i),
    .grad_i (grad_n_q),
    .pos_i  (n_q),
    .term_o (term_n)
  );

  // phases and sine lookups
  stce_phase u_phase_e (
    .clk_i  (clk_i),
    .pos_i  (e_q),
    .rate_i (rate_q),
    .req_o  (req_e)
  );

  stce_phase u_phase_n (
    .clk_i  (clk_i),
    .pos_i  (n_q),
    .rate_i (rate_q),
    .req_o  (req_n)
  );

  stce_sine_rom u_sine_rom (
    .clk_i    (clk_i),
    .req_a_i  (req_e),
    .req_b_i  (req_n),
    .sine_a_o (sine_e),
    .sine_b_o (sine_n)
  );

  // plane sum runs alongside the sine read
  assign plane_d = {{(SUM_W-REG_W){base_q[REG_W-1]}}, base_q}
                 + {{(SUM_W-GRAD_W){term_e[GRAD_W-1]}}, term_e}
                 + {{(SUM_W-GRAD_W){term_n[GRAD_W-1]}}, term_n};

  // undulation: product of sines, rounded, then scaled by amplitude
  assign sprod_d   = PR_W'(sine_e) * PR_W'(sine_n);
  assign sprod_rnd = sprod_q + ROUND_Q30;
  assign p_d       = sprod_rnd[30 +: SINE_W];
  assign up_d      = PR_W'(amp_q) * PR_W'(p_q);
  assign up_rnd    = up_q + ROUND_Q30;
  assign und       = up_rnd[PR_W-1:30];

  // final sum and saturation
  assign total = plane8_q + {{(SUM_W-UN_W){und[UN_W-1]}}, und};

  always_comb begin
    if (total > ELEV_MAX) begin
      elev_d = ELEV_MAX[ELEV_W-1:0];
      sat_d  = 1'b1;
    end else if (total < ELEV_MIN) begin
      elev_d = ELEV_MIN[ELEV_W-1:0];
      sat_d  = 1'b1;
    end else begin
      elev_d = total[ELEV_W-1:0];
      sat_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    plane5_q <= plane_d;
    plane6_q <= plane5_q;
    plane7_q <= plane6_q;
    plane8_q <= plane7_q;
    sprod_q  <= sprod_d;
    p_q      <= p_d;
    up_q     <= up_d;
    elev_q   <= elev_d;
    sat_q    <= sat_d;
  end

  assign result_strobe_o = valid_q[PIPE_DEPTH-1];
  assign elevation_o     = elev_q;
  assign saturated_o     = sat_q;

endmodule
